// File: hw/rtl/symmetric_pair_link_table_assert.svh
// assertion macros for the pair link table
`ifndef SYMMETRIC_PAIR_LINK_TABLE_ASSERT_SVH
`define SYMMETRIC_PAIR_LINK_TABLE_ASSERT_SVH

// same-cycle implication
`define SPLT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("splt same-cycle check failed");

// next-cycle implication
`define SPLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("splt next-cycle check failed");

`endif

// File: hw/rtl/splt_pkg.sv
`default_nettype none

package splt_pkg;

  localparam int BLOCK_COUNT       = 16;
  localparam int ENTRIES_PER_BLOCK = 16;
  localparam int SLOT_COUNT        = BLOCK_COUNT * ENTRIES_PER_BLOCK;
  localparam int SLOT_W            = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ID_W              = 32;
  localparam int ACT_W             = 2;
  localparam int ST_W              = 2;

  localparam logic [ACT_W-1:0] ACT_LINK   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UNLINK = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_REJECTED  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0] first;
    logic [ID_W-1:0] second;
    logic [ID_W-1:0] stamp;
    logic [ID_W-1:0] ops;
  } entry_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  first;
    logic [ID_W-1:0]  second;
    logic [ID_W-1:0]  ops;
    logic [ID_W-1:0]  stamp;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] partner;
    logic [ID_W-1:0] first;
    logic [ID_W-1:0] second;
    logic [ID_W-1:0] stamp;
    logic [ID_W-1:0] ops;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/symmetric_pair_link_table.sv
// channel   direction  handshake              payload
// request   in         start, busy            action_i first_id_i second_id_i ops_value_i now_i
// result    out        result_valid_o strobe  status_o partner_id_o found_*_o
//
// a request is taken when start is high and busy is low
// a scan reads the slot memory one entry per cycle, up to all SLOT_COUNT slots;
// a rejected link answers in the next cycle
// the result is shown for one cycle only, the receiver cannot stall it
// rst_ni clears the per-slot valid bits at once, so every slot starts free
// with no clearing pass
`default_nettype none

module symmetric_pair_link_table (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [splt_pkg::ACT_W-1:0]   action_i,
  input  wire logic [splt_pkg::ID_W-1:0]    first_id_i,
  input  wire logic [splt_pkg::ID_W-1:0]    second_id_i,
  input  wire logic [splt_pkg::ID_W-1:0]    ops_value_i,
  input  wire logic [splt_pkg::ID_W-1:0]    now_i,
  output logic                              result_valid_o,
  output logic [splt_pkg::ST_W-1:0]         status_o,
  output logic [splt_pkg::ID_W-1:0]         partner_id_o,
  output logic [splt_pkg::ID_W-1:0]         found_first_id_o,
  output logic [splt_pkg::ID_W-1:0]         found_second_id_o,
  output logic [splt_pkg::ID_W-1:0]         found_time_o,
  output logic [splt_pkg::ID_W-1:0]         found_ops_o
);

  import splt_pkg::*;

  `include "symmetric_pair_link_table_assert.svh"

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                state_q, state_d;
  req_t                req_q, req_d;
  res_t                res_q, res_d, res_n;
  logic                res_vld_q, res_vld_d;
  logic [SLOT_W:0]     addr_q, addr_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [SLOT_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic                have_free_q, have_free_d;
  logic [SLOT_W-1:0]   free_idx_q, free_idx_d;

  entry_t              mem_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_q;
  entry_t              rd_data_q;
  logic                rd_vld_q;
  logic                rd_en;
  logic [SLOT_W-1:0]   rd_idx;
  logic                wr_en;
  logic                wr_vld;
  logic [SLOT_W-1:0]   wr_idx;
  entry_t              wr_data;

  entry_t              ent;
  logic                hold;
  logic                is_free;
  logic                last;
  logic                done;
  logic                reject;

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_idx] <= wr_vld;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_idx];
      end
    end
  end

  always_comb begin
    ent     = rd_vld_q ? rd_data_q : '0;
    hold    = ((ent.first == req_q.first) && (ent.second == req_q.second)) ||
              ((ent.first == req_q.second) && (ent.second == req_q.first));
    is_free = (ent.first == '0) && (ent.second == '0);
    last    = (cmp_idx_q == SLOT_W'(SLOT_COUNT - 1));
    reject  = (first_id_i == '0) || (second_id_i == '0) || (first_id_i == second_id_i);

    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    res_n       = '0;
    res_vld_d   = 1'b0;
    addr_d      = addr_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    have_free_d = have_free_q;
    free_idx_d  = free_idx_q;
    rd_en       = 1'b0;
    rd_idx      = addr_q[SLOT_W-1:0];
    wr_en       = 1'b0;
    wr_vld      = 1'b1;
    wr_idx      = cmp_idx_q;
    wr_data     = ent;
    done        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d       = '{action: action_i, first: first_id_i, second: second_id_i,
                          ops: ops_value_i, stamp: now_i};
          addr_d      = '0;
          have_free_d = 1'b0;
          if ((action_i == ACT_LINK) && reject) begin
            res_d        = '0;
            res_d.status = ST_REJECTED;
            res_vld_d    = 1'b1;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (addr_q < (SLOT_W+1)'(SLOT_COUNT)) begin
          rd_en     = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = addr_q[SLOT_W-1:0];
          addr_d    = addr_q + (SLOT_W+1)'(1);
        end
        if (cmp_vld_q) begin
          case (req_q.action)
            ACT_LINK: begin
              if (hold) begin
                wr_en         = 1'b1;
                wr_data.stamp = req_q.stamp;
                wr_data.ops   = req_q.ops;
                res_n.status  = ST_OK;
                done          = 1'b1;
              end else begin
                if (is_free && !have_free_q) begin
                  have_free_d = 1'b1;
                  free_idx_d  = cmp_idx_q;
                end
                if (last) begin
                  done = 1'b1;
                  if (have_free_q || is_free) begin
                    wr_en   = 1'b1;
                    wr_idx  = have_free_q ? free_idx_q : cmp_idx_q;
                    wr_data = '{first: req_q.first, second: req_q.second,
                                stamp: req_q.stamp, ops: req_q.ops};
                    res_n.status = ST_OK;
                  end else begin
                    res_n.status = ST_FULL;
                  end
                end
              end
            end
            ACT_UNLINK: begin
              if (hold) begin
                wr_en        = 1'b1;
                wr_vld       = 1'b0;
                wr_data      = '0;
                res_n.status = ST_OK;
                done         = 1'b1;
              end else if (last) begin
                res_n.status = ST_NOT_FOUND;
                done         = 1'b1;
              end
            end
            ACT_LOOKUP: begin
              if (ent.first == req_q.first) begin
                res_n.partner = ent.second;
                res_n.status  = ST_OK;
                done          = 1'b1;
              end else if (ent.second == req_q.first) begin
                res_n.partner = ent.first;
                res_n.status  = ST_OK;
                done          = 1'b1;
              end else if (last) begin
                res_n.status = ST_NOT_FOUND;
                done         = 1'b1;
              end
            end
            default: begin
              if ((ent.first == req_q.first) || (ent.second == req_q.first)) begin
                res_n.first  = ent.first;
                res_n.second = ent.second;
                res_n.stamp  = ent.stamp;
                res_n.ops    = ent.ops;
                res_n.status = ST_OK;
                done         = 1'b1;
              end else if (last) begin
                res_n.status = ST_NOT_FOUND;
                done         = 1'b1;
              end
            end
          endcase
        end
        if (done) begin
          state_d   = S_IDLE;
          cmp_vld_d = 1'b0;
          res_vld_d = 1'b1;
          res_d     = res_n;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_vld_q   <= 1'b0;
      addr_q      <= '0;
      cmp_vld_q   <= 1'b0;
      have_free_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_vld_q   <= res_vld_d;
      addr_q      <= addr_d;
      cmp_vld_q   <= cmp_vld_d;
      have_free_q <= have_free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    cmp_idx_q  <= cmp_idx_d;
    free_idx_q <= free_idx_d;
  end

  assign busy              = (state_q == S_SCAN);
  assign result_valid_o    = res_vld_q;
  assign status_o          = res_q.status;
  assign partner_id_o      = res_q.partner;
  assign found_first_id_o  = res_q.first;
  assign found_second_id_o = res_q.second;
  assign found_time_o      = res_q.stamp;
  assign found_ops_o       = res_q.ops;

  `SPLT_ASSERT_NOW(a_result_not_busy, result_valid_o, !busy)
  `SPLT_ASSERT_NEXT(a_request_progresses, start && !busy, busy || result_valid_o)
  `SPLT_ASSERT_NEXT(a_reject_answers, start && !busy && (action_i == ACT_LINK) && reject,
                    result_valid_o && (status_o == ST_REJECTED))
  `SPLT_ASSERT_NEXT(a_write_ends_scan, wr_en, result_valid_o && !busy)

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import splt_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int POOL_SIZE   = 12;

  typedef struct {
    req_t rq;
    bit   known;
    res_t want;
  } row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [ACT_W-1:0]  action_i;
  logic [ID_W-1:0]   first_id_i;
  logic [ID_W-1:0]   second_id_i;
  logic [ID_W-1:0]   ops_value_i;
  logic [ID_W-1:0]   now_i;
  logic              result_valid_o;
  logic [ST_W-1:0]   status_o;
  logic [ID_W-1:0]   partner_id_o;
  logic [ID_W-1:0]   found_first_id_o;
  logic [ID_W-1:0]   found_second_id_o;
  logic [ID_W-1:0]   found_time_o;
  logic [ID_W-1:0]   found_ops_o;

  // shadow copy of the pair table
  logic [ID_W-1:0] tbl_first  [SLOT_COUNT];
  logic [ID_W-1:0] tbl_second [SLOT_COUNT];
  logic [ID_W-1:0] tbl_stamp  [SLOT_COUNT];
  logic [ID_W-1:0] tbl_ops    [SLOT_COUNT];

  logic [ID_W-1:0] id_pool [POOL_SIZE];
  res_t            pending_answers [$];
  row_t            directed_rows [$];
  res_t            head_answer;
  int              fault_count;
  int              cycle_count;
  bit              idle_on;

  symmetric_pair_link_table dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .action_i          (action_i),
    .first_id_i        (first_id_i),
    .second_id_i       (second_id_i),
    .ops_value_i       (ops_value_i),
    .now_i             (now_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .partner_id_o      (partner_id_o),
    .found_first_id_o  (found_first_id_o),
    .found_second_id_o (found_second_id_o),
    .found_time_o      (found_time_o),
    .found_ops_o       (found_ops_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int find_pair(logic [ID_W-1:0] x, logic [ID_W-1:0] y);
    int hit;
    hit = -1;
    for (int k = 0; k < SLOT_COUNT && hit < 0; k++) begin
      if ((tbl_first[k] == x && tbl_second[k] == y) ||
          (tbl_first[k] == y && tbl_second[k] == x)) begin
        hit = k;
      end
    end
    return hit;
  endfunction

  function automatic int count_vacant();
    int n;
    n = 0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (tbl_first[k] == '0 && tbl_second[k] == '0) begin
        n++;
      end
    end
    return n;
  endfunction

  function automatic res_t link_table_apply(req_t rq);
    res_t ans;
    int   hit;
    int   vacant;
    bit   got;
    ans        = '0;
    ans.status = ST_NOT_FOUND;
    got        = 1'b0;
    case (rq.action)
      ACT_LINK: begin
        if (rq.first == '0 || rq.second == '0 || rq.first == rq.second) begin
          ans.status = ST_REJECTED;
        end else begin
          hit    = find_pair(rq.first, rq.second);
          vacant = find_pair('0, '0);
          if (hit >= 0) begin
            tbl_stamp[hit] = rq.stamp;
            tbl_ops[hit]   = rq.ops;
            ans.status     = ST_OK;
          end else if (vacant >= 0) begin
            tbl_first[vacant]  = rq.first;
            tbl_second[vacant] = rq.second;
            tbl_stamp[vacant]  = rq.stamp;
            tbl_ops[vacant]    = rq.ops;
            ans.status         = ST_OK;
          end else begin
            ans.status = ST_FULL;
          end
        end
      end
      ACT_UNLINK: begin
        hit = find_pair(rq.first, rq.second);
        if (hit >= 0) begin
          tbl_first[hit]  = '0;
          tbl_second[hit] = '0;
          tbl_stamp[hit]  = '0;
          tbl_ops[hit]    = '0;
          ans.status      = ST_OK;
        end
      end
      ACT_LOOKUP: begin
        for (int k = 0; k < SLOT_COUNT && !got; k++) begin
          if (tbl_first[k] == rq.first) begin
            ans.partner = tbl_second[k];
            got         = 1'b1;
          end else if (tbl_second[k] == rq.first) begin
            ans.partner = tbl_first[k];
            got         = 1'b1;
          end
        end
        if (got) begin
          ans.status = ST_OK;
        end
      end
      default: begin
        for (int k = 0; k < SLOT_COUNT && !got; k++) begin
          if (tbl_first[k] == rq.first || tbl_second[k] == rq.first) begin
            ans.first  = tbl_first[k];
            ans.second = tbl_second[k];
            ans.stamp  = tbl_stamp[k];
            ans.ops    = tbl_ops[k];
            got        = 1'b1;
          end
        end
        if (got) begin
          ans.status = ST_OK;
        end
      end
    endcase
    return ans;
  endfunction

  function automatic void add_row(logic [ACT_W-1:0] act, logic [ID_W-1:0] a,
                                  logic [ID_W-1:0] b, logic [ID_W-1:0] ops,
                                  logic [ID_W-1:0] stamp, bit known,
                                  logic [ST_W-1:0] st, logic [ID_W-1:0] partner,
                                  logic [ID_W-1:0] f, logic [ID_W-1:0] s,
                                  logic [ID_W-1:0] t, logic [ID_W-1:0] o);
    row_t r;
    r.rq.action    = act;
    r.rq.first     = a;
    r.rq.second    = b;
    r.rq.ops       = ops;
    r.rq.stamp     = stamp;
    r.known        = known;
    r.want.status  = st;
    r.want.partner = partner;
    r.want.first   = f;
    r.want.second  = s;
    r.want.stamp   = t;
    r.want.ops     = o;
    directed_rows.push_back(r);
  endfunction

  // table_ids: draw identifiers mostly from what the table holds
  function automatic logic [ID_W-1:0] pick_id(bit table_ids);
    int r;
    int k;
    r = $urandom_range(15);
    k = $urandom_range(SLOT_COUNT - 1);
    if (r == 0) begin
      return '0;
    end
    if (r == 1) begin
      return $urandom;
    end
    if (table_ids) begin
      return (r[0]) ? tbl_first[k] : tbl_second[k];
    end
    return id_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic req_t random_request(bit table_ids);
    req_t rq;
    int   sel;
    int   k;
    sel       = $urandom_range(9);
    rq.action = (sel < 4) ? ACT_LINK : (sel < 6) ? ACT_UNLINK :
                (sel < 8) ? ACT_LOOKUP : ACT_READ;
    rq.first  = pick_id(table_ids);
    rq.second = pick_id(table_ids);
    rq.ops    = $urandom;
    rq.stamp  = $urandom;
    if (table_ids && $urandom_range(1) == 1) begin
      k = $urandom_range(SLOT_COUNT - 1);
      if ($urandom_range(1) == 1) begin
        rq.first  = tbl_first[k];
        rq.second = tbl_second[k];
      end else begin
        rq.first  = tbl_second[k];
        rq.second = tbl_first[k];
      end
    end
    return rq;
  endfunction

  task automatic send_request(input req_t rq, input bit known, input res_t want);
    int   gap;
    res_t ans;
    gap = 0;
    if (idle_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(12, 1);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    action_i    <= rq.action;
    first_id_i  <= rq.first;
    second_id_i <= rq.second;
    ops_value_i <= rq.ops;
    now_i       <= rq.stamp;
    do @(posedge clk_i); while (busy);
    ans = link_table_apply(rq);
    pending_answers.push_back(known ? want : ans);
  endtask

  function automatic void compare_field(string name, logic [ID_W-1:0] want,
                                        logic [ID_W-1:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
      fault_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected result: expected none, actual status %0d",
                 $time, status_o);
        fault_count++;
      end else begin
        head_answer = pending_answers.pop_front();
        compare_field("status", ID_W'(head_answer.status), ID_W'(status_o));
        compare_field("partner_id", head_answer.partner, partner_id_o);
        compare_field("found_first_id", head_answer.first, found_first_id_o);
        compare_field("found_second_id", head_answer.second, found_second_id_o);
        compare_field("found_time", head_answer.stamp, found_time_o);
        compare_field("found_ops", head_answer.ops, found_ops_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    req_t rq;
    res_t blank;
    blank       = '0;
    fault_count = 0;
    cycle_count = 0;
    idle_on     = 1'b1;
    rst_ni      = 1'b0;
    start       = 1'b0;
    action_i    = ACT_LINK;
    first_id_i  = '0;
    second_id_i = '0;
    ops_value_i = '0;
    now_i       = '0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      tbl_first[k]  = '0;
      tbl_second[k] = '0;
      tbl_stamp[k]  = '0;
      tbl_ops[k]    = '0;
    end
    id_pool[0] = 32'h1;
    id_pool[1] = 32'h2;
    id_pool[2] = 32'hFFFF_FFFF;
    id_pool[3] = 32'h8000_0000;
    for (int k = 4; k < POOL_SIZE; k++) begin
      id_pool[k] = $urandom;
    end

    // empty table, rejected pairs, extremes, update against an earlier free slot
    add_row(ACT_READ, 0, 0, 0, 0, 1'b1, ST_OK, 0, 0, 0, 0, 0);
    add_row(ACT_LOOKUP, 0, 0, 0, 0, 1'b1, ST_OK, 0, 0, 0, 0, 0);
    add_row(ACT_LOOKUP, 32'h5, 0, 0, 0, 1'b1, ST_NOT_FOUND, 0, 0, 0, 0, 0);
    add_row(ACT_READ, 32'h5, 0, 0, 0, 1'b1, ST_NOT_FOUND, 0, 0, 0, 0, 0);
    add_row(ACT_UNLINK, 0, 0, 0, 0, 1'b1, ST_OK, 0, 0, 0, 0, 0);
    add_row(ACT_UNLINK, 32'h1, 32'h2, 0, 0, 1'b1, ST_NOT_FOUND, 0, 0, 0, 0, 0);
    add_row(ACT_LINK, 0, 32'h7, 32'h11, 32'h22, 1'b1, ST_REJECTED, 0, 0, 0, 0, 0);
    add_row(ACT_LINK, 32'h7, 0, 32'h11, 32'h22, 1'b1, ST_REJECTED, 0, 0, 0, 0, 0);
    add_row(ACT_LINK, 32'h9, 32'h9, 32'h11, 32'h22, 1'b1, ST_REJECTED, 0, 0, 0, 0, 0);
    add_row(ACT_LINK, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_REJECTED,
            0, 0, 0, 0, 0);
    add_row(ACT_LINK, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,
            0, 0, 0, 0, 0);
    add_row(ACT_READ, 32'hFFFF_FFFF, 0, 0, 0, 1'b1, ST_OK,
            0, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_row(ACT_LOOKUP, 32'h1, 0, 0, 0, 1'b1, ST_OK, 32'hFFFF_FFFF, 0, 0, 0, 0);
    add_row(ACT_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 1'b1, ST_OK, 32'h1, 0, 0, 0, 0);
    add_row(ACT_LINK, 32'h3, 32'h4, 32'h1234_5678, 0, 1'b0, ST_OK, 0, 0, 0, 0, 0);
    add_row(ACT_LINK, 32'hFFFF_FFFF, 32'h1, 0, 32'hA5A5_A5A5, 1'b0, ST_OK,
            0, 0, 0, 0, 0);
    add_row(ACT_READ, 32'h1, 0, 0, 0, 1'b0, ST_OK, 0, 0, 0, 0, 0);
    add_row(ACT_UNLINK, 32'h1, 32'hFFFF_FFFF, 0, 0, 1'b1, ST_OK, 0, 0, 0, 0, 0);
    add_row(ACT_LINK, 32'h4, 32'h3, 32'h55, 32'hAA, 1'b0, ST_OK, 0, 0, 0, 0, 0);
    add_row(ACT_READ, 0, 0, 0, 0, 1'b0, ST_OK, 0, 0, 0, 0, 0);
    add_row(ACT_READ, 32'h3, 0, 0, 0, 1'b0, ST_OK, 0, 0, 0, 0, 0);
    add_row(ACT_LOOKUP, 32'h4, 0, 0, 0, 1'b0, ST_OK, 0, 0, 0, 0, 0);
    add_row(ACT_LINK, 32'h5, 32'h6, 32'hDEAD_BEEF, 32'h1, 1'b0, ST_OK, 0, 0, 0, 0, 0);
    add_row(ACT_READ, 32'h6, 0, 0, 0, 1'b0, ST_OK, 0, 0, 0, 0, 0);
    add_row(ACT_UNLINK, 32'h4, 32'h3, 0, 0, 1'b0, ST_OK, 0, 0, 0, 0, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].rq, directed_rows[i].known, directed_rows[i].want);
    end

    // dense traffic on a small set of ids
    repeat (450) begin
      send_request(random_request(1'b0), 1'b0, blank);
    end

    // fill every slot
    while (count_vacant() > 0) begin
      if ($urandom_range(7) == 0) begin
        rq        = random_request(1'b1);
        rq.action = ($urandom_range(1) == 1) ? ACT_LOOKUP : ACT_READ;
      end else begin
        rq.action = ACT_LINK;
        rq.first  = $urandom;
        rq.second = $urandom;
        rq.ops    = $urandom;
        rq.stamp  = $urandom;
      end
      send_request(rq, 1'b0, blank);
    end

    // full table
    repeat (60) begin
      send_request(random_request(1'b1), 1'b0, blank);
    end

    // drain, mostly unlinks of held pairs
    repeat (200) begin
      rq = random_request(1'b1);
      if ($urandom_range(2) != 0) begin
        rq.action = ACT_UNLINK;
      end
      send_request(rq, 1'b0, blank);
    end

    repeat (150) begin
      send_request(random_request(1'b1), 1'b0, blank);
    end

    idle_on = 1'b0;
    repeat (350) begin
      send_request(random_request($urandom_range(1) == 1), 1'b0, blank);
    end

    start <= 1'b0;
    while (pending_answers.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SLOT_COUNT + 4) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/splt_pkg.sv
hw/rtl/symmetric_pair_link_table.sv
sim/tb.sv
